FILE: hdl/circle_circle_intersection_top_macros.svh
// Assertion shorthands for the intersection block checkers.
// The enclosing module must provide clk and rst_n.
`ifndef CIRCLE_CIRCLE_INTERSECTION_TOP_MACROS_SVH
`define CIRCLE_CIRCLE_INTERSECTION_TOP_MACROS_SVH

// Same-cycle implication.
`define CCINT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CCINT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/ccint_pkg.sv
package ccint_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FIELD_W         = 32;
    localparam int AD_W            = 33;   // |dx|, |dy|
    localparam int S_W             = 64;   // squared distance on the valid path
    localparam int KM_W            = 65;   // |r0^2 - r1^2 + S|
    localparam int ROOT_W          = 64;   // sqrt(P*Q)
    localparam int NUM_W           = 98;   // rounded numerator
    localparam int QUO_W           = 41;   // quotient bits, up to the 2^40 clamp
    localparam int SUM_W           = 44;   // unsaturated coordinate

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_SAME  = 2'd1,
        STAT_APART = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] x0;
        logic signed [FIELD_W-1:0] y0;
        logic [S_W-1:0]            s;
        logic [KM_W-1:0]           km;
        logic                      kneg;
        logic [AD_W-1:0]           adx;
        logic [AD_W-1:0]           ady;
        logic                      dxneg;
        logic                      dyneg;
        logic                      upper;
        status_t                   status;
    } side_t;

    typedef struct packed {
        logic [FIELD_W-1:0] point_x;
        logic [FIELD_W-1:0] point_y;
        status_t            status;
    } res_t;

endpackage

FILE: hdl/ccint_prep.sv
module ccint_prep #(
    parameter int COORD_WIDTH = ccint_pkg::COORD_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [ccint_pkg::FIELD_W-1:0]  center0_x,
    input  logic signed [ccint_pkg::FIELD_W-1:0]  center0_y,
    input  logic [ccint_pkg::FIELD_W-2:0]         radius0,
    input  logic signed [ccint_pkg::FIELD_W-1:0]  center1_x,
    input  logic signed [ccint_pkg::FIELD_W-1:0]  center1_y,
    input  logic [ccint_pkg::FIELD_W-2:0]         radius1,
    input  logic                                  pick_upper,
    output logic [2*ccint_pkg::ROOT_W-1:0]        rad,
    output ccint_pkg::side_t                      side
);

    localparam int FW = ccint_pkg::FIELD_W;
    localparam int CW = (COORD_WIDTH < FW) ? COORD_WIDTH : FW;
    localparam int SH = FW - CW;
    localparam logic [FW-2:0] RMASK = (FW-1)'((64'd1 << (CW - 1)) - 64'd1);

    typedef struct packed {
        logic signed [FW-1:0]          x0;
        logic signed [FW-1:0]          y0;
        logic [ccint_pkg::AD_W-1:0]    adx;
        logic [ccint_pkg::AD_W-1:0]    ady;
        logic                          dxneg;
        logic                          dyneg;
        logic                          upper;
    } carry_t;

    logic signed [FW-1:0] x0_s, y0_s, x1_s, y1_s;

    // stage 1
    logic signed [FW-1:0] x0_1_reg, y0_1_reg;
    logic signed [FW:0]   dx_1_reg, dy_1_reg;
    logic [FW-2:0]        r0_1_reg, r1_1_reg;
    logic                 up_1_reg;
    // stage 2
    carry_t               c_2_reg;
    logic [FW-1:0]        sum_2_reg;
    logic [FW-2:0]        dif_2_reg, r0_2_reg, r1_2_reg;
    // stage 3
    carry_t               c_3_reg;
    logic [2*ccint_pkg::AD_W-1:0] adx2_3_reg, ady2_3_reg;
    logic [2*FW-1:0]      sp_3_reg;
    logic [2*FW-3:0]      sm_3_reg, r0sq_3_reg, r1sq_3_reg;
    // stage 4
    carry_t               c_4_reg;
    logic [2*ccint_pkg::AD_W-1:0] ssum_4_reg;
    logic [2*FW-1:0]      sp_4_reg;
    logic [2*FW-3:0]      sm_4_reg, r0sq_4_reg, r1sq_4_reg;
    // stage 5
    carry_t               c_5_reg;
    ccint_pkg::status_t   st_5_reg;
    logic [ccint_pkg::S_W-1:0]  s_5_reg, p_5_reg, q_5_reg;
    logic [ccint_pkg::KM_W-1:0] a_5_reg;
    logic [2*FW-3:0]      r1sq_5_reg;
    // stage 6
    carry_t               c_6_reg;
    ccint_pkg::status_t   st_6_reg;
    logic [ccint_pkg::S_W-1:0]  s_6_reg;
    logic [ccint_pkg::KM_W-1:0] km_6_reg;
    logic                 kneg_6_reg;
    logic [63:0]          pll_6_reg, plh_6_reg, phl_6_reg, phh_6_reg;
    // stage 7
    logic [2*ccint_pkg::ROOT_W-1:0] rad_reg;
    ccint_pkg::side_t     side_reg;

    logic [ccint_pkg::KM_W-1:0] r1ext;

    assign x0_s = (center0_x <<< SH) >>> SH;
    assign y0_s = (center0_y <<< SH) >>> SH;
    assign x1_s = (center1_x <<< SH) >>> SH;
    assign y1_s = (center1_y <<< SH) >>> SH;
    assign r1ext = ccint_pkg::KM_W'(r1sq_5_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_1_reg <= x0_s;
            y0_1_reg <= y0_s;
            dx_1_reg <= (FW+1)'(x1_s) - (FW+1)'(x0_s);
            dy_1_reg <= (FW+1)'(y1_s) - (FW+1)'(y0_s);
            r0_1_reg <= radius0 & RMASK;
            r1_1_reg <= radius1 & RMASK;
            up_1_reg <= pick_upper;

            c_2_reg.x0    <= x0_1_reg;
            c_2_reg.y0    <= y0_1_reg;
            c_2_reg.adx   <= dx_1_reg[FW] ? ccint_pkg::AD_W'(-dx_1_reg)
                                          : ccint_pkg::AD_W'(dx_1_reg);
            c_2_reg.ady   <= dy_1_reg[FW] ? ccint_pkg::AD_W'(-dy_1_reg)
                                          : ccint_pkg::AD_W'(dy_1_reg);
            c_2_reg.dxneg <= dx_1_reg[FW];
            c_2_reg.dyneg <= dy_1_reg[FW];
            c_2_reg.upper <= up_1_reg;
            sum_2_reg <= FW'(r0_1_reg) + FW'(r1_1_reg);
            dif_2_reg <= (r0_1_reg > r1_1_reg) ? r0_1_reg - r1_1_reg : r1_1_reg - r0_1_reg;
            r0_2_reg  <= r0_1_reg;
            r1_2_reg  <= r1_1_reg;

            c_3_reg    <= c_2_reg;
            adx2_3_reg <= (2*ccint_pkg::AD_W)'(c_2_reg.adx) * (2*ccint_pkg::AD_W)'(c_2_reg.adx);
            ady2_3_reg <= (2*ccint_pkg::AD_W)'(c_2_reg.ady) * (2*ccint_pkg::AD_W)'(c_2_reg.ady);
            sp_3_reg   <= (2*FW)'(sum_2_reg) * (2*FW)'(sum_2_reg);
            sm_3_reg   <= (2*FW-2)'(dif_2_reg) * (2*FW-2)'(dif_2_reg);
            r0sq_3_reg <= (2*FW-2)'(r0_2_reg) * (2*FW-2)'(r0_2_reg);
            r1sq_3_reg <= (2*FW-2)'(r1_2_reg) * (2*FW-2)'(r1_2_reg);

            c_4_reg    <= c_3_reg;
            ssum_4_reg <= adx2_3_reg + ady2_3_reg;
            sp_4_reg   <= sp_3_reg;
            sm_4_reg   <= sm_3_reg;
            r0sq_4_reg <= r0sq_3_reg;
            r1sq_4_reg <= r1sq_3_reg;

            c_5_reg  <= c_4_reg;
            st_5_reg <= (ssum_4_reg == '0) ? ccint_pkg::STAT_SAME :
                        ((ssum_4_reg > (2*ccint_pkg::AD_W)'(sp_4_reg)) ||
                         (ssum_4_reg < (2*ccint_pkg::AD_W)'(sm_4_reg))) ?
                        ccint_pkg::STAT_APART : ccint_pkg::STAT_OK;
            s_5_reg  <= ssum_4_reg[ccint_pkg::S_W-1:0];
            p_5_reg  <= sp_4_reg - ssum_4_reg[ccint_pkg::S_W-1:0];
            q_5_reg  <= ssum_4_reg[ccint_pkg::S_W-1:0] - ccint_pkg::S_W'(sm_4_reg);
            a_5_reg  <= ccint_pkg::KM_W'(ssum_4_reg[ccint_pkg::S_W-1:0])
                        + ccint_pkg::KM_W'(r0sq_4_reg);
            r1sq_5_reg <= r1sq_4_reg;

            c_6_reg    <= c_5_reg;
            st_6_reg   <= st_5_reg;
            s_6_reg    <= s_5_reg;
            kneg_6_reg <= a_5_reg < r1ext;
            km_6_reg   <= (a_5_reg >= r1ext) ? a_5_reg - r1ext : r1ext - a_5_reg;
            // split the 64x64 product into 32x32 partials
            pll_6_reg  <= 64'(p_5_reg[31:0])  * 64'(q_5_reg[31:0]);
            plh_6_reg  <= 64'(p_5_reg[31:0])  * 64'(q_5_reg[63:32]);
            phl_6_reg  <= 64'(p_5_reg[63:32]) * 64'(q_5_reg[31:0]);
            phh_6_reg  <= 64'(p_5_reg[63:32]) * 64'(q_5_reg[63:32]);

            rad_reg <= 128'(pll_6_reg) + (128'(plh_6_reg) << 32)
                       + (128'(phl_6_reg) << 32) + (128'(phh_6_reg) << 64);
            side_reg.x0     <= c_6_reg.x0;
            side_reg.y0     <= c_6_reg.y0;
            side_reg.s      <= s_6_reg;
            side_reg.km     <= km_6_reg;
            side_reg.kneg   <= kneg_6_reg;
            side_reg.adx    <= c_6_reg.adx;
            side_reg.ady    <= c_6_reg.ady;
            side_reg.dxneg  <= c_6_reg.dxneg;
            side_reg.dyneg  <= c_6_reg.dyneg;
            side_reg.upper  <= c_6_reg.upper;
            side_reg.status <= st_6_reg;
        end
    end

    assign rad  = rad_reg;
    assign side = side_reg;

endmodule

FILE: hdl/ccint_sqrt.sv
module ccint_sqrt #(
    parameter int RW = ccint_pkg::ROOT_W
) (
    input  logic            clk,
    input  logic            en,
    input  logic [2*RW-1:0] radicand,
    output logic [RW-1:0]   root
);

    localparam int REMW = RW + 2;

    logic [REMW-1:0] rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [2*RW-1:0] rad_reg  [RW];

    logic [REMW-1:0] rem_in   [RW];
    logic [RW-1:0]   root_in  [RW];
    logic [2*RW-1:0] rad_in   [RW];
    logic [REMW-1:0] rem_next [RW];
    logic [RW-1:0]   root_next[RW];
    logic [2*RW-1:0] rad_next [RW];

    // one result bit per stage: bring down two radicand bits, try root*4+1
    always_comb
    begin
        logic [REMW+1:0] t;
        logic [REMW+1:0] trial;
        logic            take;
        rem_in[0]  = '0;
        root_in[0] = '0;
        rad_in[0]  = radicand;
        for (int i = 1; i < RW; i++)
        begin
            rem_in[i]  = rem_reg[i-1];
            root_in[i] = root_reg[i-1];
            rad_in[i]  = rad_reg[i-1];
        end
        for (int i = 0; i < RW; i++)
        begin
            t     = {rem_in[i], rad_in[i][2*RW-1 -: 2]};
            trial = {2'b00, root_in[i], 2'b01};
            take  = t >= trial;
            rem_next[i]  = take ? REMW'(t - trial) : REMW'(t);
            root_next[i] = {root_in[i][RW-2:0], take};
            rad_next[i]  = {rad_in[i][2*RW-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < RW; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
                rad_reg[i]  <= rad_next[i];
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule

FILE: hdl/ccint_div.sv
module ccint_div #(
    parameter int NW = ccint_pkg::NUM_W,
    parameter int DW = ccint_pkg::KM_W,
    parameter int QW = ccint_pkg::QUO_W
) (
    input  logic                clk,
    input  logic                en,
    input  logic [NW-1:0]       mag,
    input  logic [DW-2:0]       half,
    input  logic                neg,
    output logic signed [QW:0]  quo
);

    localparam logic [QW-1:0] CAP = {1'b1, {(QW-1){1'b0}}};
    localparam int CW = NW + DW;

    // entry stage: numerator with the rounding bias, divisor 2s
    logic [NW-1:0] n_reg;
    logic [DW-1:0] d_a_reg;
    logic          neg_a_reg;

    logic [DW-1:0] rem_reg  [QW+1];
    logic [QW-1:0] q_reg    [QW+1];
    logic [QW-1:0] low_reg  [QW+1];
    logic [DW-1:0] d_reg    [QW+1];
    logic          ovf_reg  [QW+1];
    logic          neg_reg  [QW+1];

    logic [DW-1:0] rem_next [QW+1];
    logic [QW-1:0] q_next   [QW+1];
    logic [QW-1:0] low_next [QW+1];

    logic [QW-1:0] m;
    logic signed [QW:0] quo_reg;

    always_comb
    begin
        logic [DW:0] t;
        logic        take;
        rem_next[0] = DW'(n_reg[NW-1:QW]);
        q_next[0]   = '0;
        low_next[0] = n_reg[QW-1:0];
        for (int j = 1; j <= QW; j++)
        begin
            t    = {rem_reg[j-1], low_reg[j-1][QW-1]};
            take = t >= {1'b0, d_reg[j-1]};
            rem_next[j] = take ? DW'(t - {1'b0, d_reg[j-1]}) : DW'(t);
            q_next[j]   = {q_reg[j-1][QW-2:0], take};
            low_next[j] = {low_reg[j-1][QW-2:0], 1'b0};
        end
    end

    // clamp to 2^40 when the quotient exceeds 2^40 or would need more than QW bits
    assign m = (ovf_reg[QW] || q_reg[QW] > CAP) ? CAP : q_reg[QW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg     <= mag + NW'(half);
            d_a_reg   <= {half, 1'b0};
            neg_a_reg <= neg;

            ovf_reg[0] <= CW'(n_reg[NW-1:QW]) >= CW'(d_a_reg);
            d_reg[0]   <= d_a_reg;
            neg_reg[0] <= neg_a_reg;
            for (int j = 1; j <= QW; j++)
            begin
                ovf_reg[j] <= ovf_reg[j-1];
                d_reg[j]   <= d_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
            end
            for (int j = 0; j <= QW; j++)
            begin
                rem_reg[j] <= rem_next[j];
                q_reg[j]   <= q_next[j];
                low_reg[j] <= low_next[j];
            end

            quo_reg <= neg_reg[QW] ? -$signed({1'b0, m}) : $signed({1'b0, m});
        end
    end

    assign quo = quo_reg;

endmodule

FILE: hdl/ccint_outq.sv
module ccint_outq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ccint_pkg::res_t   push_data,
    input  logic              pop_ready,
    output logic              pop_valid,
    output ccint_pkg::res_t   pop_data,
    output logic              full
);

    ccint_pkg::res_t mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign pop_valid  = count_reg != 2'd0;
    assign full       = count_reg == 2'd2;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];
    assign count_next = count_reg + 2'(push) - 2'(pop);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: hdl/circle_circle_intersection_top.sv
// Two-circle crossing point, fully pipelined: one word in per clock while in_ready
// is high, one result word out per word in, in order. A word passes a 7-stage
// front end for distances and squares, the 64-step square-root pipeline of the
// half-chord and the 41-step dividers for the four offsets. A two-word output
// queue lets the pipe keep taking words while a result waits; status 1 flags
// coincident centres, status 2 circles that do not meet, and both return a zero
// point.
module circle_circle_intersection_top #(
    parameter int COORD_WIDTH = ccint_pkg::COORD_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [ccint_pkg::FIELD_W-1:0]  center0_x,
    input  logic signed [ccint_pkg::FIELD_W-1:0]  center0_y,
    input  logic [ccint_pkg::FIELD_W-2:0]         radius0,
    input  logic signed [ccint_pkg::FIELD_W-1:0]  center1_x,
    input  logic signed [ccint_pkg::FIELD_W-1:0]  center1_y,
    input  logic [ccint_pkg::FIELD_W-2:0]         radius1,
    input  logic                                  pick_upper,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [ccint_pkg::FIELD_W-1:0]  point_x,
    output logic signed [ccint_pkg::FIELD_W-1:0]  point_y,
    output logic [1:0]                            status
);

    localparam int FW      = ccint_pkg::FIELD_W;
    localparam int CW      = (COORD_WIDTH < FW) ? COORD_WIDTH : FW;
    localparam int RW      = ccint_pkg::ROOT_W;
    localparam int NW      = ccint_pkg::NUM_W;
    localparam int QW      = ccint_pkg::QUO_W;
    localparam int AW      = ccint_pkg::AD_W;
    localparam int SW      = ccint_pkg::SUM_W;
    localparam int PREP_LAT = 7;
    localparam int SQ_LAT   = RW;
    localparam int MUL_LAT  = 2;
    localparam int DIV_LAT  = QW + 3;
    localparam int TOTAL    = PREP_LAT + SQ_LAT + MUL_LAT + DIV_LAT + 1;
    localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_LO = SW'(-(64'sd1 <<< (CW - 1)));

    typedef struct packed {
        logic signed [FW-1:0] x0;
        logic signed [FW-1:0] y0;
        logic                 upper;
        ccint_pkg::status_t   status;
    } fin_t;

    logic                pipe_en;
    logic [TOTAL-1:0]    vld_reg;
    logic                q_full;

    logic [2*RW-1:0]     rad;
    ccint_pkg::side_t    prep_side;
    ccint_pkg::side_t    sq_side_reg [SQ_LAT];
    logic [RW-1:0]       root;

    // multiply stage 1
    ccint_pkg::side_t    m1_side_reg;
    logic [2*AW-1:0]     kx_lo_reg, ky_lo_reg;
    logic [2*AW-2:0]     kx_hi_reg, ky_hi_reg;
    logic [RW/2+AW-1:0]  hx_lo_reg, hx_hi_reg, hy_lo_reg, hy_hi_reg;
    // multiply stage 2
    fin_t                m2_fin_reg;
    logic [RW-1:0]       m2_s_reg;
    logic [NW-1:0]       mox_reg, moy_reg, mhx_reg, mhy_reg;
    logic                nox_reg, noy_reg, nhx_reg, nhy_reg;

    logic signed [QW:0]  ox, oy, hx, hy;
    fin_t                dv_fin_reg [DIV_LAT];

    // final sums
    fin_t                f_fin_reg;
    logic signed [SW-1:0] x31_reg, y31_reg, x32_reg, y32_reg;

    logic                pick31;
    logic signed [SW-1:0] px, py, pxs, pys;
    ccint_pkg::res_t     res, q_data;

    // stall only when the queue is full and a result is ready to leave the pipe
    assign pipe_en  = !(q_full && vld_reg[TOTAL-1]);
    assign in_ready = pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (pipe_en)
        begin
            vld_reg <= {vld_reg[TOTAL-2:0], in_valid};
        end
    end

    ccint_prep #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_prep (
        .clk        (clk),
        .en         (pipe_en),
        .center0_x  (center0_x),
        .center0_y  (center0_y),
        .radius0    (radius0),
        .center1_x  (center1_x),
        .center1_y  (center1_y),
        .radius1    (radius1),
        .pick_upper (pick_upper),
        .rad        (rad),
        .side       (prep_side)
    );

    ccint_sqrt #(
        .RW (RW)
    ) u_sqrt (
        .clk      (clk),
        .en       (pipe_en),
        .radicand (rad),
        .root     (root)
    );

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            sq_side_reg[0] <= prep_side;
            for (int i = 1; i < SQ_LAT; i++)
            begin
                sq_side_reg[i] <= sq_side_reg[i-1];
            end

            m1_side_reg <= sq_side_reg[SQ_LAT-1];
            kx_lo_reg <= (2*AW)'(sq_side_reg[SQ_LAT-1].km[AW-1:0])
                         * (2*AW)'(sq_side_reg[SQ_LAT-1].adx);
            kx_hi_reg <= (2*AW-1)'(sq_side_reg[SQ_LAT-1].km[ccint_pkg::KM_W-1:AW])
                         * (2*AW-1)'(sq_side_reg[SQ_LAT-1].adx);
            ky_lo_reg <= (2*AW)'(sq_side_reg[SQ_LAT-1].km[AW-1:0])
                         * (2*AW)'(sq_side_reg[SQ_LAT-1].ady);
            ky_hi_reg <= (2*AW-1)'(sq_side_reg[SQ_LAT-1].km[ccint_pkg::KM_W-1:AW])
                         * (2*AW-1)'(sq_side_reg[SQ_LAT-1].ady);
            hx_lo_reg <= (RW/2+AW)'(root[RW/2-1:0]) * (RW/2+AW)'(sq_side_reg[SQ_LAT-1].ady);
            hx_hi_reg <= (RW/2+AW)'(root[RW-1:RW/2]) * (RW/2+AW)'(sq_side_reg[SQ_LAT-1].ady);
            hy_lo_reg <= (RW/2+AW)'(root[RW/2-1:0]) * (RW/2+AW)'(sq_side_reg[SQ_LAT-1].adx);
            hy_hi_reg <= (RW/2+AW)'(root[RW-1:RW/2]) * (RW/2+AW)'(sq_side_reg[SQ_LAT-1].adx);

            m2_fin_reg.x0     <= m1_side_reg.x0;
            m2_fin_reg.y0     <= m1_side_reg.y0;
            m2_fin_reg.upper  <= m1_side_reg.upper;
            m2_fin_reg.status <= m1_side_reg.status;
            m2_s_reg <= m1_side_reg.s;
            mox_reg  <= NW'(kx_lo_reg) + (NW'(kx_hi_reg) << AW);
            moy_reg  <= NW'(ky_lo_reg) + (NW'(ky_hi_reg) << AW);
            mhx_reg  <= NW'(hx_lo_reg) + (NW'(hx_hi_reg) << (RW/2));
            mhy_reg  <= NW'(hy_lo_reg) + (NW'(hy_hi_reg) << (RW/2));
            nox_reg  <= m1_side_reg.kneg ^ m1_side_reg.dxneg;
            noy_reg  <= m1_side_reg.kneg ^ m1_side_reg.dyneg;
            nhx_reg  <= m1_side_reg.dyneg;
            nhy_reg  <= m1_side_reg.dxneg;

            dv_fin_reg[0] <= m2_fin_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                dv_fin_reg[i] <= dv_fin_reg[i-1];
            end

            f_fin_reg <= dv_fin_reg[DIV_LAT-1];
            x31_reg <= SW'(dv_fin_reg[DIV_LAT-1].x0) + SW'(ox) + SW'(hx);
            y31_reg <= SW'(dv_fin_reg[DIV_LAT-1].y0) + SW'(oy) - SW'(hy);
            x32_reg <= SW'(dv_fin_reg[DIV_LAT-1].x0) + SW'(ox) - SW'(hx);
            y32_reg <= SW'(dv_fin_reg[DIV_LAT-1].y0) + SW'(oy) + SW'(hy);
        end
    end

    ccint_div #(.NW(NW), .DW(ccint_pkg::KM_W), .QW(QW)) u_div_ox (
        .clk (clk), .en (pipe_en), .mag (mox_reg), .half (m2_s_reg), .neg (nox_reg), .quo (ox)
    );
    ccint_div #(.NW(NW), .DW(ccint_pkg::KM_W), .QW(QW)) u_div_oy (
        .clk (clk), .en (pipe_en), .mag (moy_reg), .half (m2_s_reg), .neg (noy_reg), .quo (oy)
    );
    ccint_div #(.NW(NW), .DW(ccint_pkg::KM_W), .QW(QW)) u_div_hx (
        .clk (clk), .en (pipe_en), .mag (mhx_reg), .half (m2_s_reg), .neg (nhx_reg), .quo (hx)
    );
    ccint_div #(.NW(NW), .DW(ccint_pkg::KM_W), .QW(QW)) u_div_hy (
        .clk (clk), .en (pipe_en), .mag (mhy_reg), .half (m2_s_reg), .neg (nhy_reg), .quo (hy)
    );

    // upper takes the first point only when it is strictly higher
    assign pick31 = (y31_reg > y32_reg) == f_fin_reg.upper;
    assign px  = pick31 ? x31_reg : x32_reg;
    assign py  = pick31 ? y31_reg : y32_reg;
    assign pxs = (px > SAT_HI) ? SAT_HI : ((px < SAT_LO) ? SAT_LO : px);
    assign pys = (py > SAT_HI) ? SAT_HI : ((py < SAT_LO) ? SAT_LO : py);

    always_comb
    begin
        res.status = f_fin_reg.status;
        if (f_fin_reg.status == ccint_pkg::STAT_OK)
        begin
            res.point_x = pxs[FW-1:0];
            res.point_y = pys[FW-1:0];
        end
        else
        begin
            res.point_x = '0;
            res.point_y = '0;
        end
    end

    ccint_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (pipe_en && vld_reg[TOTAL-1]),
        .push_data (res),
        .pop_ready (out_ready),
        .pop_valid (out_valid),
        .pop_data  (q_data),
        .full      (q_full)
    );

    assign point_x = q_data.point_x;
    assign point_y = q_data.point_y;
    assign status  = q_data.status;

endmodule

FILE: hdl/ccint_chk.sv
`include "circle_circle_intersection_top_macros.svh"

module ccint_chk (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [ccint_pkg::FIELD_W-1:0] point_x,
    input logic signed [ccint_pkg::FIELD_W-1:0] point_y,
    input logic [1:0]                           status
);

    `CCINT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "stalled result word dropped")
    `CCINT_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(point_x) && $stable(point_y) && $stable(status), "stalled result word changed")
    `CCINT_ASSERT_NOW(a_bad_zero, out_valid && status != ccint_pkg::STAT_OK, point_x == 0 && point_y == 0, "flagged result carries a nonzero point")
    `CCINT_ASSERT_NOW(a_idle_ready, !out_valid, in_ready, "input held off while output queue is empty")

endmodule

bind circle_circle_intersection_top ccint_chk u_ccint_chk (.*);
